[rtl/tibd_pkg.sv]
// Shared types and constants for the tape image block deframer.
// No dependencies; tibd_summary, tibd_skid and the top level use this package.
`timescale 1ns / 1ps

package tibd_pkg;

  localparam int LENGTH_BITS_DEF = 24;
  localparam int SIG_LEN = 8;
  localparam int NAME_START = 10;
  localparam int HEADER_MIN = 16;
  localparam int NAME_BYTES = 6;

  localparam logic [7:0] SIGNATURE [SIG_LEN] = '{
    8'h1f, 8'ha6, 8'hde, 8'hba, 8'hcc, 8'h13, 8'h7d, 8'h74
  };

  localparam logic [7:0] MARK_BINARY = 8'hd0;
  localparam logic [7:0] MARK_BASIC  = 8'hd3;
  localparam logic [7:0] MARK_ASCII  = 8'hea;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_NUL    = 8'h00;

  localparam logic [1:0] TYPE_DATA   = 2'd0;
  localparam logic [1:0] TYPE_BINARY = 2'd1;
  localparam logic [1:0] TYPE_BASIC  = 2'd2;
  localparam logic [1:0] TYPE_ASCII  = 2'd3;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic {
    MODE_RUN,
    MODE_FLUSH
  } mode_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [1:0]  block_type;
    logic [47:0] name_bytes;
    logic [2:0]  name_length;
    logic [23:0] block_length;
    logic        no_header;
    logic        file_done;
    logic        last_of_run;
  } res_t;

endpackage

[rtl/tibd_in_if.sv]
// Input channel of the deframer: one raw tape image byte per transfer.
// Depends on nothing.
`timescale 1ns / 1ps

interface tibd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_file;

  modport source (output valid, output in_byte, output end_of_file, input ready);
  modport sink (input valid, input in_byte, input end_of_file, output ready);
endinterface

[rtl/tibd_res_if.sv]
// Result channel of the deframer: one data byte or block summary per transfer.
// Depends on nothing.
`timescale 1ns / 1ps

interface tibd_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic [1:0]  block_type;
  logic [47:0] name_bytes;
  logic [2:0]  name_length;
  logic [23:0] block_length;
  logic        no_header;
  logic        file_done;
  logic        last_of_run;

  modport source (output valid, output kind, output data_byte, output block_type,
                  output name_bytes, output name_length, output block_length,
                  output no_header, output file_done, output last_of_run, input ready);
  modport sink (input valid, input kind, input data_byte, input block_type,
                input name_bytes, input name_length, input block_length,
                input no_header, input file_done, input last_of_run, output ready);
endinterface

[rtl/tibd_summary.sv]
// Block end summary: header classification and name trimming.
// Depends on tibd_pkg.
`timescale 1ns / 1ps

module tibd_summary #(
  parameter int LENGTH_BITS = tibd_pkg::LENGTH_BITS_DEF
) (
  input  logic [LENGTH_BITS-1:0] byte_count,
  input  logic [7:0]             marker_byte,
  input  logic                   marker_run_ok,
  input  logic [47:0]            name_store,
  input  logic                   done,
  input  logic                   last,
  output tibd_pkg::res_t         summ
);

  logic                            is_header;
  logic [tibd_pkg::NAME_BYTES-1:0] keep;
  logic                            seen;
  logic [LENGTH_BITS+23:0]         count_ext;

  assign is_header = marker_run_ok &&
                     (byte_count >= LENGTH_BITS'(tibd_pkg::HEADER_MIN));
  assign count_ext = {24'b0, byte_count};

  // keep a name byte once a non-blank byte has been seen at or below it
  always_comb begin
    seen = 1'b0;
    keep = '0;
    for (int i = 0; i < tibd_pkg::NAME_BYTES; i++) begin
      if (name_store[8*i +: 8] != tibd_pkg::CHAR_SPACE &&
          name_store[8*i +: 8] != tibd_pkg::CHAR_NUL) begin
        seen = 1'b1;
      end
      keep[i] = seen;
    end
  end

  always_comb begin
    summ = '0;
    summ.kind = tibd_pkg::KIND_SUMMARY;
    summ.block_length = count_ext[23:0];
    summ.file_done = done;
    summ.last_of_run = last;
    if (is_header) begin
      priority if (marker_byte == tibd_pkg::MARK_BINARY) begin
        summ.block_type = tibd_pkg::TYPE_BINARY;
      end else if (marker_byte == tibd_pkg::MARK_BASIC) begin
        summ.block_type = tibd_pkg::TYPE_BASIC;
      end else begin
        summ.block_type = tibd_pkg::TYPE_ASCII;
      end
      summ.name_length = 3'($countones(keep));
      for (int i = 0; i < tibd_pkg::NAME_BYTES; i++) begin
        summ.name_bytes[8*i +: 8] = keep[i] ? name_store[8*i +: 8] : 8'h00;
      end
    end
  end

endmodule

[rtl/tibd_skid.sv]
// Two-entry result queue between the deframer core and the result channel.
// Depends on tibd_pkg and tibd_res_if.
`timescale 1ns / 1ps

module tibd_skid (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tibd_pkg::res_t push_data,
  output logic           full,
  tibd_res_if.source     result
);

  tibd_pkg::res_t ent [2];
  logic [1:0]     count;
  logic           wr_ptr;
  logic           rd_ptr;
  logic           pop;
  tibd_pkg::res_t head;

  assign pop  = result.valid && result.ready;
  assign full = count == 2'd2;
  assign head = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_data;
    end
  end

  assign result.valid        = count != 2'd0;
  assign result.kind         = head.kind;
  assign result.data_byte    = head.data_byte;
  assign result.block_type   = head.block_type;
  assign result.name_bytes   = head.name_bytes;
  assign result.name_length  = head.name_length;
  assign result.block_length = head.block_length;
  assign result.no_header    = head.no_header;
  assign result.file_done    = head.file_done;
  assign result.last_of_run  = head.last_of_run;

endmodule

[rtl/tape_image_block_deframer.sv]
// Tape image block deframer top level: signature window, block accounting, flush.
// Depends on tibd_pkg, tibd_in_if, tibd_res_if, tibd_summary and tibd_skid.
//
//   channel  direction  carries
//   feed     sink       in_byte, end_of_file
//   result   source     kind, data_byte, block_type, name_bytes, name_length,
//                       block_length, no_header, file_done, last_of_run
//
// One byte per cycle while feed.ready is high; a byte gives at most one result,
// formed in the same cycle. A byte marked end_of_file starts a flush with feed.ready
// low: it drains the bytes left in the seven-byte window, then gives the summary
// inside a block, or it gives the no-header result outside one; a full queue stalls
// the flush; the two-entry result queue registers back-pressure for feed.ready.
// Synchronous reset clears the window fill, block state and queue.
`timescale 1ns / 1ps

module tape_image_block_deframer #(
  parameter int LENGTH_BITS = tibd_pkg::LENGTH_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  tibd_in_if.sink  feed,
  tibd_res_if.source result
);

  localparam int WIN = tibd_pkg::SIG_LEN - 1;

  logic [7:0]             window [WIN];
  logic [7:0]             window_next [WIN];
  logic [2:0]             fill;
  logic [2:0]             fill_next;
  logic                   in_block;
  logic                   in_block_next;
  logic [LENGTH_BITS-1:0] byte_count;
  logic [LENGTH_BITS-1:0] byte_count_next;
  logic [7:0]             marker_byte;
  logic [7:0]             marker_byte_next;
  logic                   marker_run_ok;
  logic                   marker_run_ok_next;
  logic [47:0]            name_store;
  logic [47:0]            name_store_next;
  tibd_pkg::mode_t        mode;
  tibd_pkg::mode_t        mode_next;

  logic           q_full;
  logic           in_fire;
  logic           full;
  logic           sig_hit;
  logic           step_sum;
  logic           step_data;
  logic           flush_go;
  logic           flush_data;
  logic           flush_end;
  logic           restart;
  logic           push;
  tibd_pkg::res_t push_data;
  tibd_pkg::res_t summ;

  assign feed.ready = (mode == tibd_pkg::MODE_RUN) && !q_full;
  assign in_fire    = feed.valid && feed.ready;
  assign full       = fill == 3'(WIN);
  assign flush_go   = (mode == tibd_pkg::MODE_FLUSH) && !q_full;
  assign flush_data = flush_go && in_block && (fill != 3'd0);
  assign flush_end  = flush_go && (!in_block || (fill == 3'd0));
  assign step_sum   = in_fire && sig_hit && in_block;
  assign step_data  = in_fire && full && !sig_hit && in_block;
  assign restart    = (in_fire && sig_hit) || flush_end;

  always_comb begin
    sig_hit = full && (feed.in_byte == tibd_pkg::SIGNATURE[WIN]);
    for (int i = 0; i < WIN; i++) begin
      if (window[i] != tibd_pkg::SIGNATURE[i]) begin
        sig_hit = 1'b0;
      end
    end
  end

  tibd_summary #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_summary (
    .byte_count    (byte_count),
    .marker_byte   (marker_byte),
    .marker_run_ok (marker_run_ok),
    .name_store    (name_store),
    .done          (flush_end),
    .last          (flush_end || !feed.end_of_file),
    .summ          (summ)
  );

  // next mode
  always_comb begin
    mode_next = mode;
    unique case (mode)
      tibd_pkg::MODE_RUN: begin
        if (in_fire && feed.end_of_file) begin
          mode_next = tibd_pkg::MODE_FLUSH;
        end
      end
      tibd_pkg::MODE_FLUSH: begin
        if (flush_end) begin
          mode_next = tibd_pkg::MODE_RUN;
        end
      end
      default: mode_next = tibd_pkg::MODE_RUN;
    endcase
  end

  // result to queue
  always_comb begin
    push      = step_sum || step_data || flush_data || flush_end;
    push_data = '0;
    priority if (step_sum || (flush_end && in_block)) begin
      push_data = summ;
    end else if (step_data || flush_data) begin
      push_data.kind        = tibd_pkg::KIND_DATA;
      push_data.data_byte   = window[0];
      push_data.last_of_run = step_data && !feed.end_of_file;
    end else if (flush_end) begin
      push_data.kind        = tibd_pkg::KIND_SUMMARY;
      push_data.no_header   = 1'b1;
      push_data.file_done   = 1'b1;
      push_data.last_of_run = 1'b1;
    end else begin
      push_data = '0;
    end
  end

  // window
  always_comb begin
    window_next = window;
    fill_next   = fill;
    priority if (in_fire) begin
      priority if (sig_hit) begin
        fill_next = 3'd0;
      end else if (full) begin
        for (int i = 0; i < WIN - 1; i++) begin
          window_next[i] = window[i+1];
        end
        window_next[WIN-1] = feed.in_byte;
      end else begin
        window_next[fill] = feed.in_byte;
        fill_next = fill + 3'd1;
      end
    end else if (flush_data) begin
      for (int i = 0; i < WIN - 1; i++) begin
        window_next[i] = window[i+1];
      end
      fill_next = fill - 3'd1;
    end else if (flush_end) begin
      fill_next = 3'd0;
    end else begin
      fill_next = fill;
    end
  end

  // block accounting for the byte leaving the window
  always_comb begin
    in_block_next      = in_block;
    byte_count_next    = byte_count;
    marker_byte_next   = marker_byte;
    marker_run_ok_next = marker_run_ok;
    name_store_next    = name_store;
    if (in_fire && sig_hit) begin
      in_block_next = 1'b1;
    end else if (flush_end) begin
      in_block_next = 1'b0;
    end
    priority if (restart) begin
      byte_count_next    = '0;
      marker_byte_next   = 8'h00;
      marker_run_ok_next = 1'b1;
      name_store_next    = '0;
    end else if (step_data || flush_data) begin
      priority if (byte_count == '0) begin
        marker_byte_next   = window[0];
        marker_run_ok_next = (window[0] == tibd_pkg::MARK_BINARY) ||
                             (window[0] == tibd_pkg::MARK_BASIC) ||
                             (window[0] == tibd_pkg::MARK_ASCII);
      end else if (byte_count < LENGTH_BITS'(tibd_pkg::NAME_START)) begin
        if (window[0] != marker_byte) begin
          marker_run_ok_next = 1'b0;
        end
      end else if (byte_count < LENGTH_BITS'(tibd_pkg::HEADER_MIN)) begin
        name_store_next = {name_store[39:0], window[0]};
      end else begin
        name_store_next = name_store;
      end
      if (byte_count != '1) begin
        byte_count_next = byte_count + LENGTH_BITS'(1);
      end
    end else begin
      byte_count_next = byte_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= tibd_pkg::MODE_RUN;
      fill          <= 3'd0;
      in_block      <= 1'b0;
      byte_count    <= '0;
      marker_byte   <= 8'h00;
      marker_run_ok <= 1'b1;
      name_store    <= '0;
    end else begin
      mode          <= mode_next;
      fill          <= fill_next;
      in_block      <= in_block_next;
      byte_count    <= byte_count_next;
      marker_byte   <= marker_byte_next;
      marker_run_ok <= marker_run_ok_next;
      name_store    <= name_store_next;
    end
  end

  always_ff @(posedge clk) begin
    window <= window_next;
  end

  tibd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .result    (result)
  );

`ifndef NO_ASSERTIONS
  a_eof_flush: assert property (@(posedge clk) disable iff (rst)
    in_fire && feed.end_of_file |=> mode == tibd_pkg::MODE_FLUSH)
    else $error("end of file transfer did not start the flush");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    push && push_data.file_done |-> push_data.last_of_run && push_data.kind)
    else $error("final result not marked last");

  a_data_in_block: assert property (@(posedge clk) disable iff (rst)
    push && (push_data.kind == tibd_pkg::KIND_DATA) |-> in_block)
    else $error("data byte outside a block");

  a_flush_end_reset: assert property (@(posedge clk) disable iff (rst)
    flush_end |=> (mode == tibd_pkg::MODE_RUN) && !in_block && (fill == 3'd0))
    else $error("state not cleared after end of file");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push)
    else $error("result pushed into a full queue");
`endif

endmodule
